// ===== sv/weighted_multilevel_queue_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef WEIGHTED_MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH
`define WEIGHTED_MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WMLQ_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WMLQ_ASSERT_NXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== sv/wmlq_pkg.sv =====
// Shared types, constants and codes of the weighted multilevel queue scheduler.
package wmlq_pkg;

    // Slot geometry; SLOTS must stay a power of two (ring pointers wrap naturally)
    localparam int SLOTS      = 16;
    localparam int NQUEUES    = 3;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int QUEUE_W    = 2;
    localparam int ADDR_W     = QUEUE_W + SLOT_W;
    localparam int RAM_DEPTH  = NQUEUES * SLOTS;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int ID_W       = 16;
    localparam int QUANT_W    = 24;
    localparam int CNT_W      = 4;
    localparam int SLOT_IDX_W = 4;
    localparam int DATA_W     = ID_W + QUANT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Queue depths between the parts
    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCHED  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 2'd3;

    // Configuration reset values
    localparam logic [QUANT_W-1:0] BASE_RST   = 24'd10000000;
    localparam logic [CNT_W-1:0]   CYCLE_RST  = 4'd10;
    localparam logic [CNT_W-1:0]   FIRST_RST  = 4'd6;
    localparam logic [CNT_W-1:0]   SECOND_RST = 4'd9;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Queue numbers picked by the schedule
    localparam logic [QUEUE_W-1:0] QUEUE_HI  = 2'd0;
    localparam logic [QUEUE_W-1:0] QUEUE_MID = 2'd1;
    localparam logic [QUEUE_W-1:0] QUEUE_LO  = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_REMOVE,
        CMD_SCHED,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [ID_W-1:0]      id;
        logic [QUEUE_W-1:0]   queue;
    } cmd_t;

    typedef struct packed {
        logic                  status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  out_valid;
        logic [ID_W-1:0]       out_proc_id;
        logic [QUANT_W-1:0]    out_quantum;
        logic [QUEUE_W-1:0]    out_queue;
    } res_t;

    typedef struct packed {
        logic [QUANT_W-1:0] base_quantum;
        logic [CNT_W-1:0]   cycle_length;
        logic [CNT_W-1:0]   first_threshold;
        logic [CNT_W-1:0]   second_threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HEAD = 3'b100
    } back_state_t;

endpackage

// ===== sv/wmlq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wmlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wmlq_front.sv =====
// Front part: accepts requests, classifies them and queues commands for the back part.
module wmlq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [wmlq_pkg::MODE_W-1:0]   mode,
    input  logic [wmlq_pkg::ID_W-1:0]     proc_id,
    input  logic [wmlq_pkg::QUEUE_W-1:0]  priority_req,
    output logic                          cmd_valid,
    output wmlq_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    localparam int PTR_W = (wmlq_pkg::CMDQ_DEPTH > 1) ? $clog2(wmlq_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(wmlq_pkg::CMDQ_DEPTH + 1);

    wmlq_pkg::cmd_t   cmdq_reg [wmlq_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    wmlq_pkg::cmd_t   cmd_in;
    logic             do_push;
    logic             do_pop;
    logic             bad_queue;

    // Classify the incoming request
    always_comb
    begin
        bad_queue    = (priority_req >= wmlq_pkg::QUEUE_W'(wmlq_pkg::NQUEUES));
        cmd_in.id    = proc_id;
        cmd_in.queue = priority_req;
        case (mode)
            wmlq_pkg::MODE_ADD:    cmd_in.kind = bad_queue ? wmlq_pkg::CMD_REJECT
                                                           : wmlq_pkg::CMD_ADD;
            wmlq_pkg::MODE_REMOVE: cmd_in.kind = bad_queue ? wmlq_pkg::CMD_REJECT
                                                           : wmlq_pkg::CMD_REMOVE;
            wmlq_pkg::MODE_SCHED:  cmd_in.kind = wmlq_pkg::CMD_SCHED;
            default:               cmd_in.kind = wmlq_pkg::CMD_REJECT;
        endcase
    end

    assign full      = (count_reg == CNT_W'(wmlq_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cmdq_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(wmlq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(wmlq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmdq_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== sv/wmlq_res_queue.sv =====
// Result queue between the back part and the result ports.
module wmlq_res_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_push,
    input  wmlq_pkg::res_t res_in,
    output logic           res_room,
    output logic           empty,
    input  logic           pop,
    output wmlq_pkg::res_t res_out
);

    localparam int PTR_W = (wmlq_pkg::RESQ_DEPTH > 1) ? $clog2(wmlq_pkg::RESQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(wmlq_pkg::RESQ_DEPTH + 1);

    wmlq_pkg::res_t   resq_reg [wmlq_pkg::RESQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign res_room = (count_reg != CNT_W'(wmlq_pkg::RESQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign res_out  = resq_reg[rd_ptr_reg];
    assign do_push  = res_push && res_room;
    assign do_pop   = pop && !empty;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(wmlq_pkg::RESQ_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(wmlq_pkg::RESQ_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold waiting results
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            resq_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ===== sv/wmlq_back.sv =====
// Back part: executes add, remove and schedule commands on the slot store.
module wmlq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  wmlq_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    input  wmlq_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           res_room,
    output logic           res_push,
    output wmlq_pkg::res_t res,
    output logic           busy
);

    localparam int SW = wmlq_pkg::SLOT_W;

    // Each queue is a ring: logical slot i lives at physical slot head + i
    wmlq_pkg::back_state_t                           state_reg, state_next;
    logic [wmlq_pkg::NQUEUES-1:0][wmlq_pkg::SLOTS-1:0] valid_reg, valid_next;
    logic [wmlq_pkg::NQUEUES-1:0][SW-1:0]             head_reg, head_next;
    logic [wmlq_pkg::CNT_W-1:0]                       sched_cnt_reg, sched_cnt_next;
    wmlq_pkg::cmd_t                                   cur_reg, cur_next;
    logic [SW:0]                                      iss_reg, iss_next;
    logic                                             pend_vld_reg, pend_vld_next;
    logic [SW-1:0]                                    pend_idx_reg, pend_idx_next;
    logic                                             hd_vld_reg, hd_vld_next;
    logic [wmlq_pkg::QUEUE_W-1:0]                     hd_queue_reg, hd_queue_next;

    logic                              ram_we;
    logic [wmlq_pkg::ADDR_W-1:0]       ram_waddr;
    logic [wmlq_pkg::DATA_W-1:0]       ram_wdata;
    logic [wmlq_pkg::ADDR_W-1:0]       ram_raddr;
    logic [wmlq_pkg::DATA_W-1:0]       ram_rdata;

    logic [wmlq_pkg::SLOTS-1:0]        add_lvalid;
    logic                              free_found;
    logic [SW-1:0]                     free_idx;
    logic [SW-1:0]                     free_phys;
    logic [wmlq_pkg::QUANT_W-1:0]      add_quant;
    logic [wmlq_pkg::QUEUE_W-1:0]      sched_q;
    logic [SW-1:0]                     sched_head;
    logic [wmlq_pkg::CNT_W:0]          cnt_inc;
    logic [wmlq_pkg::CNT_W-1:0]        cnt_wrap;
    logic [SW-1:0]                     scan_phys;
    logic [SW-1:0]                     issue_phys;
    logic                              scan_hit;
    logic                              scan_last;

    // Slot store: process id and quantum per slot
    wmlq_ram #(
        .WIDTH (wmlq_pkg::DATA_W),
        .DEPTH (wmlq_pkg::RAM_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Find the lowest free logical slot of the add queue
    always_comb
    begin
        for (int i = 0; i < wmlq_pkg::SLOTS; i++)
        begin
            add_lvalid[i] = valid_reg[cmd.queue][head_reg[cmd.queue] + SW'(i)];
        end
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = wmlq_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!add_lvalid[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
        free_phys = head_reg[cmd.queue] + free_idx;
        add_quant = cfg.base_quantum >> cmd.queue;
    end

    // Pick the schedule queue and the next counter value
    always_comb
    begin
        if (sched_cnt_reg < cfg.first_threshold)
        begin
            sched_q = wmlq_pkg::QUEUE_HI;
        end
        else if (sched_cnt_reg < cfg.second_threshold)
        begin
            sched_q = wmlq_pkg::QUEUE_MID;
        end
        else
        begin
            sched_q = wmlq_pkg::QUEUE_LO;
        end
        sched_head = head_reg[sched_q];
        cnt_inc    = {1'b0, sched_cnt_reg} + 1'b1;
        cnt_wrap   = (cnt_inc >= {1'b0, cfg.cycle_length}) ? '0
                                                          : cnt_inc[wmlq_pkg::CNT_W-1:0];
    end

    // Compare the slot read last cycle against the remove id
    always_comb
    begin
        scan_phys  = head_reg[cur_reg.queue] + pend_idx_reg;
        issue_phys = head_reg[cur_reg.queue] + iss_reg[SW-1:0];
        scan_hit   = pend_vld_reg && valid_reg[cur_reg.queue][scan_phys]
                     && (ram_rdata[wmlq_pkg::DATA_W-1 -: wmlq_pkg::ID_W] == cur_reg.id);
        scan_last  = pend_vld_reg && (pend_idx_reg == SW'(wmlq_pkg::SLOTS - 1));
    end

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        sched_cnt_next = sched_cnt_reg;
        cur_next       = cur_reg;
        iss_next       = iss_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        hd_vld_next    = hd_vld_reg;
        hd_queue_next  = hd_queue_reg;
        ram_we         = 1'b0;
        ram_waddr      = {cmd.queue, free_phys};
        ram_wdata      = {cmd.id, add_quant};
        ram_raddr      = {cur_reg.queue, issue_phys};
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res            = '0;

        case (state_reg)
            wmlq_pkg::ST_IDLE:
            begin
                if (cmd_valid && res_room)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        wmlq_pkg::CMD_ADD:
                        begin
                            res_push = 1'b1;
                            if (free_found)
                            begin
                                ram_we                          = 1'b1;
                                valid_next[cmd.queue][free_phys] = 1'b1;
                                res.status      = wmlq_pkg::STATUS_OK;
                                res.slot_index  = wmlq_pkg::SLOT_IDX_W'(free_idx);
                                res.out_quantum = add_quant;
                            end
                            else
                            begin
                                res.status = wmlq_pkg::STATUS_FAIL;
                            end
                        end
                        wmlq_pkg::CMD_REMOVE:
                        begin
                            cur_next      = cmd;
                            iss_next      = '0;
                            pend_vld_next = 1'b0;
                            state_next    = wmlq_pkg::ST_SCAN;
                        end
                        wmlq_pkg::CMD_SCHED:
                        begin
                            // Pop the head: drop its valid bit and advance the ring
                            ram_raddr                     = {sched_q, sched_head};
                            hd_vld_next                   = valid_reg[sched_q][sched_head];
                            hd_queue_next                 = sched_q;
                            valid_next[sched_q][sched_head] = 1'b0;
                            head_next[sched_q]            = sched_head + 1'b1;
                            sched_cnt_next                = cnt_wrap;
                            state_next                    = wmlq_pkg::ST_HEAD;
                        end
                        default:
                        begin
                            res_push   = 1'b1;
                            res.status = wmlq_pkg::STATUS_FAIL;
                        end
                    endcase
                end
            end
            wmlq_pkg::ST_HEAD:
            begin
                res_push      = 1'b1;
                res.status    = wmlq_pkg::STATUS_OK;
                res.out_valid = hd_vld_reg;
                res.out_queue = hd_queue_reg;
                if (hd_vld_reg)
                begin
                    res.out_proc_id = ram_rdata[wmlq_pkg::DATA_W-1 -: wmlq_pkg::ID_W];
                    res.out_quantum = ram_rdata[wmlq_pkg::QUANT_W-1:0];
                end
                state_next = wmlq_pkg::ST_IDLE;
            end
            wmlq_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    valid_next[cur_reg.queue][scan_phys] = 1'b0;
                    res_push       = 1'b1;
                    res.status     = wmlq_pkg::STATUS_OK;
                    res.slot_index = wmlq_pkg::SLOT_IDX_W'(pend_idx_reg);
                    state_next     = wmlq_pkg::ST_IDLE;
                end
                else if (scan_last)
                begin
                    res_push   = 1'b1;
                    res.status = wmlq_pkg::STATUS_FAIL;
                    state_next = wmlq_pkg::ST_IDLE;
                end
                else
                begin
                    // Issue the next slot read; it is compared in the following cycle
                    pend_vld_next = 1'b1;
                    pend_idx_next = iss_reg[SW-1:0];
                    iss_next      = iss_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = wmlq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != wmlq_pkg::ST_IDLE);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wmlq_pkg::ST_IDLE;
            valid_reg     <= '0;
            head_reg      <= '0;
            sched_cnt_reg <= '0;
            iss_reg       <= '0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            sched_cnt_reg <= sched_cnt_next;
            iss_reg       <= iss_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    // Payload of the command in progress
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pend_idx_reg <= pend_idx_next;
        hd_vld_reg   <= hd_vld_next;
        hd_queue_reg <= hd_queue_next;
    end

endmodule

// ===== sv/weighted_multilevel_queue_scheduler.sv =====
// Top level of the weighted multilevel queue scheduler.
// Add and rejected requests give their result without a slot read; schedule reads the head
// slot, and remove reads one slot per cycle until it finds the id or reaches the last slot.
// One add or reject is taken per cycle while the result queue has room; no new command
// is taken while a schedule or remove is in progress.
// Reset clears slot valid bits, ring heads and the schedule counter and loads config defaults.
`include "weighted_multilevel_queue_scheduler_macros.svh"
module weighted_multilevel_queue_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [wmlq_pkg::MODE_W-1:0]       mode,
    input  logic [wmlq_pkg::ID_W-1:0]         proc_id,
    input  logic [wmlq_pkg::QUEUE_W-1:0]      priority_req,
    output logic                              empty,
    input  logic                              pop,
    output logic                              status,
    output logic [wmlq_pkg::SLOT_IDX_W-1:0]   slot_index,
    output logic                              out_valid,
    output logic [wmlq_pkg::ID_W-1:0]         out_proc_id,
    output logic [wmlq_pkg::QUANT_W-1:0]      out_quantum,
    output logic [wmlq_pkg::QUEUE_W-1:0]      out_queue,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wmlq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wmlq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    wmlq_pkg::cfg_t cfg_reg, cfg_next;
    wmlq_pkg::cmd_t cmd;
    wmlq_pkg::res_t res;
    wmlq_pkg::res_t res_out;
    logic           cmd_valid;
    logic           cmd_pop;
    logic           res_push;
    logic           res_room;
    logic           back_busy;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wmlq_pkg::CFG_BASE:   cfg_next.base_quantum     = cfg_data;
                wmlq_pkg::CFG_CYCLE:  cfg_next.cycle_length     = cfg_data[wmlq_pkg::CNT_W-1:0];
                wmlq_pkg::CFG_FIRST:  cfg_next.first_threshold  = cfg_data[wmlq_pkg::CNT_W-1:0];
                wmlq_pkg::CFG_SECOND: cfg_next.second_threshold = cfg_data[wmlq_pkg::CNT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_quantum     <= wmlq_pkg::BASE_RST;
            cfg_reg.cycle_length     <= wmlq_pkg::CYCLE_RST;
            cfg_reg.first_threshold  <= wmlq_pkg::FIRST_RST;
            cfg_reg.second_threshold <= wmlq_pkg::SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept and classify requests
    wmlq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .proc_id      (proc_id),
        .priority_req (priority_req),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // Execute commands on the slot store
    wmlq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_room  (res_room),
        .res_push  (res_push),
        .res       (res),
        .busy      (back_busy)
    );

    // Hold results until transfer
    wmlq_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign status      = res_out.status;
    assign slot_index  = res_out.slot_index;
    assign out_valid   = res_out.out_valid;
    assign out_proc_id = res_out.out_proc_id;
    assign out_quantum = res_out.out_quantum;
    assign out_queue   = res_out.out_queue;

    // Check the hand-off between the parts
    `WMLQ_ASSERT_IMP(a_res_room, clk, rst_n, res_push, res_room, "result queue overflow")
    `WMLQ_ASSERT_IMP(a_cmd_pop, clk, rst_n, cmd_pop, cmd_valid && !back_busy, "bad command pop")
    `WMLQ_ASSERT_NXT(a_res_visible, clk, rst_n, res_push, !empty, "pushed result not visible")

endmodule
